[hw/rtl/bam_pkg.sv]
// shared types, codes and helpers for the bit angle modulation scanner
package bam_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] CFG_UNIT   = 2'd0;
  localparam logic [1:0] CFG_OFFSET = 2'd1;
  localparam logic [1:0] CFG_EXTRA  = 2'd2;

  localparam logic [6:0] UNIT_RST   = 7'd1;
  localparam logic [7:0] OFFSET_RST = 8'd5;
  localparam logic [7:0] EXTRA_RST  = 8'd0;

  localparam logic [5:0]  BTN_MASK   = 6'h3f;
  localparam int          BASE_SHIFT = 4;
  localparam logic [15:0] PERIOD_MAX = 16'hffff;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] plane;
    logic       last;
    logic       refresh;
    logic [5:0] changed;
    logic [5:0] pressed;
  } scan_t;

  function automatic logic [5:0] swap_pairs(input logic [5:0] x);
    return {x[4], x[5], x[2], x[3], x[0], x[1]};
  endfunction

endpackage

[hw/rtl/bam_frame_store.sv]
// frame word memory with per-entry valid bits, registered read
module bam_frame_store #(
  parameter int DEPTH = 36,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [31:0]      rd_word_r;
  logic             rd_ok_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_word_r : 32'd0;

endmodule

[hw/rtl/bam_scan_ctrl.sv]
// row and plane counters, button memory and change detection
module bam_scan_ctrl #(
  parameter int ROWS   = 6,
  parameter int PLANES = 6,
  parameter int AW     = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           tick_en,
  input  logic [7:0]     button_bits,
  output logic [AW-1:0]  rd_addr,
  output bam_pkg::scan_t scan
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PW = $clog2(PLANES);

  logic [RW-1:0]  row_r, row_nxt;
  logic [PW-1:0]  plane_r, plane_nxt;
  logic [7:0]     btn_mem_r [ROWS];
  bam_pkg::scan_t scan_r, scan_nxt;
  logic           last;
  logic [5:0]     diff;
  logic [7:0]     row_ext, plane_ext;

  assign last      = (plane_r == PW'(PLANES - 1));
  assign diff      = (btn_mem_r[row_r][5:0] ^ button_bits[5:0]) & bam_pkg::BTN_MASK;
  assign row_ext   = 8'(row_r);
  assign plane_ext = 8'(plane_r);
  assign rd_addr   = AW'(row_r * PLANES + plane_r);

  always_comb begin
    scan_nxt.row     = row_ext[2:0];
    scan_nxt.plane   = plane_ext[2:0];
    scan_nxt.last    = last;
    scan_nxt.refresh = (plane_r == PW'(PLANES - 2));
    scan_nxt.changed = last ? bam_pkg::swap_pairs(diff) : 6'd0;
    scan_nxt.pressed = last ? bam_pkg::swap_pairs(diff & button_bits[5:0]) : 6'd0;
    plane_nxt        = last ? '0 : plane_r + 1'b1;
    row_nxt          = row_r;
    if (last) begin
      row_nxt = (row_r == RW'(ROWS - 1)) ? '0 : row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      plane_r <= '0;
      for (int i = 0; i < ROWS; i++) begin
        btn_mem_r[i] <= 8'd0;
      end
    end else if (tick_en) begin
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
      if (last) begin
        btn_mem_r[row_r] <= button_bits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_en) begin
      scan_r <= scan_nxt;
    end
  end

  assign scan = scan_r;

endmodule

[hw/rtl/bam_out_stage.sv]
// period computation and output register
module bam_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic           out_tready,
  input  logic [31:0]    word,
  input  bam_pkg::scan_t scan,
  input  logic [6:0]     unit,
  input  logic [7:0]     offset,
  input  logic [7:0]     extra,
  output logic           out_tvalid,
  output logic [71:0]    out_tdata,
  output logic [1:0]     out_tuser
);

  logic [18:0]    base;
  logic [19:0]    diff;
  logic [15:0]    period;
  logic           tvalid_r;
  logic [31:0]    word_r;
  logic [15:0]    period_r;
  bam_pkg::scan_t scan_r;

  assign base = 19'(unit) << (bam_pkg::BASE_SHIFT + int'(scan.plane));
  assign diff = {1'b0, base} - 20'(offset) - (scan.last ? 20'(extra) : 20'd0);

  always_comb begin
    if (diff[19]) begin
      period = 16'd0;
    end else if (diff[18:16] != 3'd0) begin
      period = bam_pkg::PERIOD_MAX;
    end else begin
      period = diff[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= 1'b0;
    end else if (load) begin
      tvalid_r <= 1'b1;
    end else if (out_tready) begin
      tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r   <= word;
      period_r <= period;
      scan_r   <= scan;
    end
  end

  assign out_tvalid = tvalid_r;
  assign out_tdata  = {6'd0, scan_r.pressed, scan_r.changed, period_r,
                       scan_r.plane, scan_r.row, word_r};
  assign out_tuser  = {scan_r.refresh, scan_r.last};

endmodule

[hw/rtl/bam_led_matrix_scanner.sv]
// top level of the bit angle modulation led and button matrix scanner
//
// in_ beats carry either a frame word write (tuser low) or a period end tick
// (tuser high). a write stores one 32-bit shift word for a row and bit plane and
// returns nothing; a write outside the matrix is dropped. a tick returns one
// out_ beat with the stored word for the current row and plane, the timer
// reload for the next period, the button change masks on the last plane and a
// colour refresh flag on the second-to-last plane.
// cfg_ writes period_unit (0), period_offset (1) and last_extra (2); it is
// always ready. the user must write it only while no tick is in flight; the
// block itself leaves this unchecked. a tick is held in the read stage and
// then the output register. throughput: one beat per cycle while out_tready
// is high, from the registered frame memory read feeding one output register.
// reset clears the counters, button memory and frame valid bits at once, so
// the block takes beats from the first cycle after reset.
// when out_tready is low, one more tick waits in the read stage and in_tready
// then drops until the output register drains.
module bam_led_matrix_scanner #(
  parameter int ROWS   = 6,
  parameter int PLANES = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // write_row, write_plane, write_word, button_bits, pad
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // drive_word, drive_row, drive_plane, period_ticks,
                                  // changed_mask, pressed_mask, pad
  output logic [1:0]  out_tuser,  // scan_valid, refresh_request
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int DEPTH = ROWS * PLANES;
  localparam int AW    = $clog2(DEPTH);

  logic           in_fire, tick_en, wr_en, advance, s1_valid_r;
  logic [2:0]     wr_row, wr_plane;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [31:0]    rd_data;
  logic [6:0]     unit_r;
  logic [7:0]     offset_r, extra_r;
  bam_pkg::scan_t scan;

  assign wr_row    = in_tdata[2:0];
  assign wr_plane  = in_tdata[5:3];
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign tick_en   = in_fire && (in_tuser == bam_pkg::OP_TICK);
  assign wr_en     = in_fire && (in_tuser == bam_pkg::OP_WRITE)
                     && (int'(wr_row) < ROWS) && (int'(wr_plane) < PLANES);
  assign wr_addr   = AW'(int'(wr_row) * PLANES + int'(wr_plane));
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      unit_r     <= bam_pkg::UNIT_RST;
      offset_r   <= bam_pkg::OFFSET_RST;
      extra_r    <= bam_pkg::EXTRA_RST;
    end else begin
      if (tick_en) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bam_pkg::CFG_UNIT:   unit_r   <= cfg_data[6:0];
          bam_pkg::CFG_OFFSET: offset_r <= cfg_data;
          bam_pkg::CFG_EXTRA:  extra_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  bam_frame_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata[37:6]),
    .rd_en   (tick_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bam_scan_ctrl #(.ROWS(ROWS), .PLANES(PLANES), .AW(AW)) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_en     (tick_en),
    .button_bits (in_tdata[45:38]),
    .rd_addr     (rd_addr),
    .scan        (scan)
  );

  bam_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_valid_r && advance),
    .out_tready (out_tready),
    .word       (rd_data),
    .scan       (scan),
    .unit       (unit_r),
    .offset     (offset_r),
    .extra      (extra_r),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_tick_staged: assert property (@(posedge clk) disable iff (!rst_n)
    tick_en |=> s1_valid_r)
    else $error("accepted tick not held in read stage");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |-> !in_tready)
    else $error("read stage overwritten while stalled");

  a_flags_apart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("scan and refresh flagged on one plane");

  a_masks_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[65:54] == 12'd0))
    else $error("button masks off the last plane");

endmodule

[bench/bam_scan_checker.sv]
// scoreboard for the scanner: tracks config and in beats, predicts each tick, checks out beats
module bam_scan_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          outstanding
);

  localparam int ROWS       = 6;
  localparam int PLANES     = 6;
  localparam int BASE_TICKS = 16;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  row;
    logic [2:0]  plane;
    logic [15:0] period;
    logic        scan;
    logic [5:0]  changed;
    logic [5:0]  pressed;
    logic        refresh;
  } drive_t;

  logic [31:0] frame_mem [0:ROWS-1][0:PLANES-1];
  logic [7:0]  btn_mem [0:ROWS-1];
  int          cur_row;
  int          cur_plane;
  logic [6:0]  unit_q;
  logic [7:0]  offset_q;
  logic [7:0]  extra_q;
  drive_t      drive_q [$];
  drive_t      want;
  int          errs = 0;

  function automatic logic [5:0] cross_pairs(input logic [5:0] x);
    return ((x & 6'h15) << 1) | ((x & 6'h2a) >> 1);
  endfunction

  function automatic logic [15:0] reload_for(input int plane);
    int p;
    p = (BASE_TICKS << plane) * int'(unit_q) - int'(offset_q);
    if (plane == PLANES - 1) p = p - int'(extra_q);
    if (p < 0) return 16'h0000;
    if (p > 65535) return 16'hffff;
    return 16'(p);
  endfunction

  function automatic drive_t tick_result(input logic [7:0] btn);
    drive_t     d;
    logic [5:0] diff;
    d         = '0;
    d.word    = frame_mem[cur_row][cur_plane];
    d.row     = 3'(cur_row);
    d.plane   = 3'(cur_plane);
    d.period  = reload_for(cur_plane);
    d.refresh = (cur_plane == PLANES - 2);
    if (cur_plane == PLANES - 1) begin
      diff      = btn_mem[cur_row][5:0] ^ btn[5:0];
      d.scan    = 1'b1;
      d.changed = cross_pairs(diff);
      d.pressed = cross_pairs(diff & btn[5:0]);
      btn_mem[cur_row] = btn;
      cur_plane = 0;
      cur_row   = (cur_row + 1) % ROWS;
    end else begin
      cur_plane = cur_plane + 1;
    end
    return d;
  endfunction

  task automatic check_field(input string what, input logic [31:0] exp_v, input logic [31:0] act);
    if (exp_v !== act) begin
      errs++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        btn_mem[r] = '0;
        for (int p = 0; p < PLANES; p++) frame_mem[r][p] = '0;
      end
      cur_row   = 0;
      cur_plane = 0;
      unit_q    = bam_pkg::UNIT_RST;
      offset_q  = bam_pkg::OFFSET_RST;
      extra_q   = bam_pkg::EXTRA_RST;
      drive_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (drive_q.size() == 0) begin
          errs++;
          $display("%0t: out beat with nothing expected, got %0h", $time, out_tdata);
        end else begin
          want = drive_q.pop_front();
          check_field("drive_word", want.word, out_tdata[31:0]);
          check_field("drive_row", 32'(want.row), 32'(out_tdata[34:32]));
          check_field("drive_plane", 32'(want.plane), 32'(out_tdata[37:35]));
          check_field("period_ticks", 32'(want.period), 32'(out_tdata[53:38]));
          check_field("changed_mask", 32'(want.changed), 32'(out_tdata[59:54]));
          check_field("pressed_mask", 32'(want.pressed), 32'(out_tdata[65:60]));
          check_field("scan_valid", 32'(want.scan), 32'(out_tuser[0]));
          check_field("refresh_request", 32'(want.refresh), 32'(out_tuser[1]));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bam_pkg::CFG_UNIT:   unit_q   = cfg_data[6:0];
          bam_pkg::CFG_OFFSET: offset_q = cfg_data;
          bam_pkg::CFG_EXTRA:  extra_q  = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == bam_pkg::OP_TICK) begin
          drive_q.push_back(tick_result(in_tdata[45:38]));
        end else if (int'(in_tdata[2:0]) < ROWS && int'(in_tdata[5:3]) < PLANES) begin
          frame_mem[in_tdata[2:0]][in_tdata[5:3]] = in_tdata[37:6];
        end
      end
    end
    outstanding <= drive_q.size();
    mismatches  <= errs;
  end

endmodule

[bench/bam_led_matrix_scanner_test.sv]
// top of the scanner bench: clock, reset, stimulus, receiver stalls and final verdict
module bam_led_matrix_scanner_test;

  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;  // write_row, write_plane, write_word, button_bits, pad
  logic        in_tuser   = 1'b0;  // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;  // drive_word, drive_row, drive_plane, period_ticks,
                           // changed_mask, pressed_mask, pad
  logic [1:0]  out_tuser;  // scan_valid, refresh_request
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [7:0]  cfg_data   = '0;

  logic [15:0] rx_cycle = '0;
  logic [1:0]  rx_mode  = '0;

  int mismatches;
  int outstanding;
  int n_writes   = 0;
  int n_ticks    = 0;
  int n_settings = 0;

  always #10 clk = ~clk;

  bam_led_matrix_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bam_scan_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // receiver stall pattern, mode reshuffled at random whenever rx_cycle[6:0] is zero
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 16'd1;
    if (rx_cycle[6:0] == 7'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= 1'($urandom);
      2'd2:    out_tready <= (rx_cycle[1:0] == 2'b00);
      default: out_tready <= (rx_cycle[4:3] == 2'b00);
    endcase
  end

  task automatic send(input logic op, input logic [2:0] row, input logic [2:0] plane,
                      input logic [31:0] word, input logic [7:0] btn);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, btn, word, plane, row};
    do @(posedge clk); while (!in_tready);
    if (op == bam_pkg::OP_TICK) n_ticks++;
    else n_writes++;
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(input logic [7:0] unit, input logic [7:0] offs, input logic [7:0] extra);
    write_reg(bam_pkg::CFG_UNIT, unit);
    write_reg(bam_pkg::CFG_OFFSET, offs);
    write_reg(bam_pkg::CFG_EXTRA, extra);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int         burst_left;
    int         roll;
    logic [7:0] steady;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: word extremes, out-of-range writes, ticks with stray write fields
    send(bam_pkg::OP_WRITE, 3'd0, 3'd0, 32'hffff_ffff, 8'h00);
    send(bam_pkg::OP_WRITE, 3'd0, 3'd1, 32'h0000_0000, 8'hff);
    send(bam_pkg::OP_WRITE, 3'd0, 3'd5, 32'h8000_0001, 8'h00);
    send(bam_pkg::OP_WRITE, 3'd6, 3'd0, 32'hdead_beef, 8'h00);
    send(bam_pkg::OP_WRITE, 3'd0, 3'd6, 32'h1234_5678, 8'h00);
    send(bam_pkg::OP_WRITE, 3'd7, 3'd7, 32'h5555_aaaa, 8'h00);
    send(bam_pkg::OP_WRITE, 3'd5, 3'd5, 32'hcafe_f00d, 8'h00);
    for (int i = 0; i < 6; i++)
      send(bam_pkg::OP_TICK, 3'd7, 3'd7, 32'hffff_ffff, (i == 5) ? 8'hff : 8'h00);
    for (int i = 0; i < 6; i++)
      send(bam_pkg::OP_TICK, 3'd0, 3'd0, 32'h0, (i == 5) ? 8'hc0 : 8'h3f);
    for (int i = 0; i < 6; i++)
      send(bam_pkg::OP_TICK, 3'd5, 3'd5, 32'h0, (i == 5) ? 8'h15 : 8'h2a);

    for (int phase = 0; phase < 7; phase++) begin
      if (phase > 0) begin
        settle();
        case (phase)
          1: set_regs(8'd127, 8'd0, 8'd0);
          2: set_regs(8'h80, 8'hff, 8'hff);
          3: set_regs(8'd1, 8'hff, 8'd0);
          4: begin
            write_reg(CFG_SPARE, 8'($urandom));
            set_regs(8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom));
          end
          default: set_regs(8'($urandom), 8'($urandom), 8'($urandom));
        endcase
      end
      steady     = 8'($urandom);
      burst_left = 0;
      repeat (90) begin
        if (burst_left == 0) begin
          pause((phase % 3 != 2) ? $urandom_range(0, 6) : 0);
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        roll = $urandom_range(0, 99);
        if (roll < 45)
          send(bam_pkg::OP_TICK, 3'($urandom), 3'($urandom), $urandom,
               (roll < 18) ? steady : 8'($urandom));
        else if (roll < 88)
          send(bam_pkg::OP_WRITE, 3'($urandom_range(0, 5)), 3'($urandom_range(0, 5)),
               $urandom, 8'($urandom));
        else if ($urandom_range(0, 1) == 0)
          send(bam_pkg::OP_WRITE, 3'($urandom_range(6, 7)), 3'($urandom), $urandom,
               8'($urandom));
        else
          send(bam_pkg::OP_WRITE, 3'($urandom), 3'($urandom_range(6, 7)), $urandom,
               8'($urandom));
      end
    end

    settle();
    $display("covered %0d frame writes and %0d ticks over %0d register settings",
             n_writes, n_ticks, n_settings + 1);
    $display("with sender gaps, receiver stalls, out-of-range writes and period clamping");
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
